/* hw/rtl/lifestep_pkg.sv */
// Shared types and codes for the toroidal life automaton.
`timescale 1ns / 1ps
`default_nettype none

package lifestep_pkg;

	localparam int unsigned CMD_W = 2;
	localparam int unsigned COL_W = 6;
	localparam int unsigned ROW_W = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE   = 2'd0,
		CMD_READ    = 2'd1,
		CMD_ADVANCE = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	// Per-cycle sweep control broadcast to every row cell.
	typedef struct packed {
		logic run;
		logic advance;
		logic last;
		logic wr_hit;
		logic rd_hit;
		logic wr_val;
	} ctl_t;

	// Three-cell window at the head of a rotating row: left, center, right.
	typedef struct packed {
		logic left;
		logic center;
		logic right;
	} win_t;

	localparam logic [3:0] BIRTH_COUNT   = 4'd3;
	localparam logic [3:0] SURVIVE_COUNT = 4'd2;

endpackage

`default_nettype wire

/* hw/rtl/lifestep_row_cell.sv */
// One grid row: a rotating row register, its next-generation buffer and the B3/S23 rule.
`timescale 1ns / 1ps
`default_nettype none

module lifestep_row_cell
	import lifestep_pkg::*;
#(
	parameter int unsigned GRID_WIDTH = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire ctl_t ctl,
	input  wire logic sel,
	input  wire win_t up_win,
	input  wire win_t down_win,
	output win_t      own_win,
	output logic      rd_bit
);

	logic [GRID_WIDTH-1:0] row_q;
	logic [GRID_WIDTH-1:0] nxt_q;
	logic [3:0]            count;
	logic                  new_bit;
	logic                  head_bit;

	assign own_win.left   = row_q[GRID_WIDTH-1];
	assign own_win.center = row_q[0];
	assign own_win.right  = row_q[1];

	assign count = {3'b000, up_win.left} + {3'b000, up_win.center} + {3'b000, up_win.right}
		+ {3'b000, row_q[GRID_WIDTH-1]} + {3'b000, row_q[1]}
		+ {3'b000, down_win.left} + {3'b000, down_win.center} + {3'b000, down_win.right};

	always_comb begin
		if (row_q[0]) begin
			new_bit = (count == SURVIVE_COUNT) || (count == BIRTH_COUNT);
		end else begin
			new_bit = (count == BIRTH_COUNT);
		end
	end

	assign head_bit = (ctl.wr_hit && sel) ? ctl.wr_val : row_q[0];
	assign rd_bit   = ctl.rd_hit && sel && row_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (ctl.run) begin
			if (ctl.advance && ctl.last) begin
				row_q <= {new_bit, nxt_q[GRID_WIDTH-1:1]};
			end else begin
				row_q <= {head_bit, row_q[GRID_WIDTH-1:1]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.run && ctl.advance) begin
			nxt_q <= {new_bit, nxt_q[GRID_WIDTH-1:1]};
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/life_automaton_step_top.sv */
// Toroidal B3/S23 life automaton: a chain of row cells driven by a column sweep.
//
// Input channel (in_valid/in_ready) carries command, column, row and cell_in.
// Output channel (out_valid/out_ready) carries cell_out, one item per input item.
// Every command, including write and read, runs one full column sweep:
// all rows rotate one column per cycle, in lockstep, and each row cell sees the
// head windows of the rows above and below. An advance builds the new row bit by
// bit in the cell's second buffer and swaps it in on the last sweep cycle; a
// write or read acts on the addressed cell as it passes the row head.
// An accepted item passes through the sweep and finish states before out_valid rises;
// one item is in work at a time, so no new item is taken until the last is finished.
// A finished item sits in the output register; the next input item is taken
// while it waits. If it is still not taken when the next sweep ends, the block
// holds that result and stays busy until the slot frees.
// Reset clears every cell to dead and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module life_automaton_step_top
	import lifestep_pkg::*;
#(
	parameter int unsigned GRID_WIDTH  = 64,
	parameter int unsigned GRID_HEIGHT = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [CMD_W-1:0] command,
	input  wire logic [COL_W-1:0] column,
	input  wire logic [ROW_W-1:0] row,
	input  wire logic             cell_in,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic                  cell_out
);

	localparam int unsigned STEP_W = $clog2(GRID_WIDTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_FINISH
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	cmd_t              cmd_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic              val_q;
	logic              rd_acc_q;
	logic              out_valid_q;
	logic              cell_out_q;

	ctl_t                   ctl;
	logic                   in_grid;
	logic                   col_match;
	logic                   last_step;
	logic [GRID_HEIGHT-1:0] rd_bits;
	logic [GRID_HEIGHT-1:0] sel;
	win_t                   wins [GRID_HEIGHT];

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign cell_out  = cell_out_q;

	assign in_grid   = (int'(col_q) < int'(GRID_WIDTH)) && (int'(row_q) < int'(GRID_HEIGHT));
	assign col_match = (int'(step_q) == int'(col_q));
	assign last_step = (step_q == STEP_W'(GRID_WIDTH - 1));

	assign ctl.run     = (state_q == ST_SWEEP);
	assign ctl.advance = (cmd_q == CMD_ADVANCE);
	assign ctl.last    = last_step;
	assign ctl.wr_hit  = (cmd_q == CMD_WRITE) && in_grid && col_match;
	assign ctl.rd_hit  = (cmd_q == CMD_READ) && in_grid && col_match;
	assign ctl.wr_val  = val_q;

	for (genvar i = 0; i < GRID_HEIGHT; i++) begin : g_row
		assign sel[i] = (int'(row_q) == i);

		lifestep_row_cell #(
			.GRID_WIDTH(GRID_WIDTH)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.sel     (sel[i]),
			.up_win  (wins[(i + GRID_HEIGHT - 1) % GRID_HEIGHT]),
			.down_win(wins[(i + 1) % GRID_HEIGHT]),
			.own_win (wins[i]),
			.rd_bit  (rd_bits[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			rd_acc_q    <= 1'b0;
			out_valid_q <= 1'b0;
			cell_out_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != ST_FINISH)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						step_q   <= '0;
						rd_acc_q <= 1'b0;
						state_q  <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					rd_acc_q <= rd_acc_q | (|rd_bits);
					if (last_step) begin
						step_q  <= '0;
						state_q <= ST_FINISH;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_FINISH: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						cell_out_q  <= rd_acc_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q <= cmd_t'(command);
			col_q <= column;
			row_q <= row;
			val_q <= cell_in;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/lifestep_checker.sv */
// Port-level checks for the life automaton top level, bound to it.
`timescale 1ns / 1ps
`default_nettype none

module lifestep_checker #(
	parameter int unsigned GRID_WIDTH = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic cell_out
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input ready right after accept");

	a_busy_whole_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> ##GRID_WIDTH !in_ready)
		else $error("input ready before sweep end");

	a_result_after_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without a sweep");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(cell_out)))
		else $error("stalled result dropped or changed");

endmodule

bind life_automaton_step_top lifestep_checker #(
	.GRID_WIDTH(GRID_WIDTH)
) u_lifestep_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.cell_out (cell_out)
);

`default_nettype wire
